>>> src/bpc_pkg.sv
// Shared types and constants of the blind position controller.
`timescale 1ns / 1ps

package bpc_pkg;

    localparam int TIME_BITS = 32;
    localparam int CNT_BITS  = $clog2(TIME_BITS);
    localparam int POS_BITS  = 7;
    localparam int CFG_BITS  = 16;
    localparam int IDX_BITS  = 3;
    localparam int IN_BITS   = 8;
    localparam int OUT_BITS  = 24;

    // register indexes of the configuration port
    localparam logic [IDX_BITS-1:0] REG_TIME_DOWN  = 3'd0;
    localparam logic [IDX_BITS-1:0] REG_TIME_UP    = 3'd1;
    localparam logic [IDX_BITS-1:0] REG_SLAT_TIME  = 3'd2;
    localparam logic [IDX_BITS-1:0] REG_RELAY_WAIT = 3'd3;
    localparam logic [IDX_BITS-1:0] REG_END_OFFSET = 3'd4;

    localparam logic [CFG_BITS-1:0] RST_TIME_DOWN  = 16'd100;
    localparam logic [CFG_BITS-1:0] RST_TIME_UP    = 16'd100;
    localparam logic [7:0]          RST_SLAT_TIME  = 8'd10;
    localparam logic [CFG_BITS-1:0] RST_RELAY_WAIT = 16'd200;
    localparam logic [CFG_BITS-1:0] RST_END_OFFSET = 16'd1000;

    localparam logic          OP_TICK  = 1'b0;
    localparam logic          OP_LEVEL = 1'b1;
    localparam logic [7:0]    LEVEL_TOGGLE = 8'hFF;
    localparam logic [7:0]    LEVEL_STOP   = 8'hC9;

    localparam logic [POS_BITS-1:0]  POS_MAX   = 7'd100;
    localparam logic [POS_BITS-1:0]  POS_RESET = 7'd50;
    localparam logic [TIME_BITS-1:0] RELAY_OFF_DELAY = TIME_BITS'(20000);

    typedef enum logic [2:0] {
        MS_STOP  = 3'd0,
        MS_WAIT  = 3'd1,
        MS_TURN  = 3'd2,
        MS_MOVE  = 3'd3,
        MS_ROFF  = 3'd4,
        MS_SWDIR = 3'd5
    } motion_t;

    typedef enum logic [1:0] {
        CTL_IDLE,
        CTL_DECIDE,
        CTL_DIVIDE,
        CTL_APPLY
    } ctl_state_t;

    typedef struct packed {
        logic load_item;
        logic div_start;
        logic apply;
    } bpc_cmd_t;

    typedef struct packed {
        logic need_div;
        logic div_last;
        logic out_free;
    } bpc_stat_t;

endpackage

>>> src/blind_position_controller.sv
// Top level of the roller-blind relay and position controller.
`timescale 1ns / 1ps

// Drives a blind motor through a motor relay and a direction relay and
// estimates position and slat angle from run time. Each input word is either
// a one-millisecond tick (tuser 0) or a level command (tuser 1: 255 toggle,
// 201 stop, else target = level/2 up to 100); every word returns one result
// word with both relay pin levels, the target, the motion state and, on
// entry into stop, the reported position. A word goes through decode and,
// when the position must be estimated, the 32-step shift-subtract divider
// that divides elapsed run time by the per-percent time, before the update.
// A new word is taken while the previous result still waits on the output.
module blind_position_controller (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [bpc_pkg::IN_BITS-1:0]   s_axis_tdata,  // [7:0] level
    input  logic                          s_axis_tuser,  // [0] operation
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [0] motor_relay_pin, [1] direction_relay_pin, [8:2] report_position,
    // [15:9] requested_position, [18:16] motion_state, [23:19] zero
    output logic [bpc_pkg::OUT_BITS-1:0]  m_axis_tdata,
    output logic                          m_axis_tuser,  // [0] report_valid
    input  logic                          cfg_we,
    input  logic [bpc_pkg::IDX_BITS-1:0]  cfg_index,
    input  logic [bpc_pkg::CFG_BITS-1:0]  cfg_wdata
);
    import bpc_pkg::*;

    bpc_cmd_t  cmd;
    bpc_stat_t stat;

    bpc_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .stat          (stat),
        .cmd           (cmd)
    );

    bpc_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .in_op         (s_axis_tuser),
        .in_level      (s_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

>>> src/bpc_ctrl.sv
// Sequencer: steps one word through decode, optional divide and update.
`timescale 1ns / 1ps

module bpc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  bpc_pkg::bpc_stat_t stat,
    output bpc_pkg::bpc_cmd_t  cmd
);
    import bpc_pkg::*;

    ctl_state_t state_reg;
    ctl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CTL_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        s_axis_tready = 1'b0;
        case (state_reg)
            CTL_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = CTL_DECIDE;
                end
            end
            CTL_DECIDE:
            begin
                if (stat.need_div)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = CTL_DIVIDE;
                end
                else
                begin
                    state_next = CTL_APPLY;
                end
            end
            CTL_DIVIDE:
            begin
                if (stat.div_last)
                begin
                    state_next = CTL_APPLY;
                end
            end
            CTL_APPLY:
            begin
                // update only once the previous result has left
                if (stat.out_free)
                begin
                    cmd.apply  = 1'b1;
                    state_next = CTL_IDLE;
                end
            end
            default:
            begin
                state_next = CTL_IDLE;
            end
        endcase
    end

endmodule

>>> src/bpc_datapath.sv
// Datapath: time base, blind state, run-time divider and result register.
`timescale 1ns / 1ps

module bpc_datapath (
    input  logic                            clk,
    input  logic                            rst_n,
    input  bpc_pkg::bpc_cmd_t               cmd,
    output bpc_pkg::bpc_stat_t              stat,
    input  logic                            in_op,
    input  logic [7:0]                      in_level,
    input  logic                            cfg_we,
    input  logic [bpc_pkg::IDX_BITS-1:0]    cfg_index,
    input  logic [bpc_pkg::CFG_BITS-1:0]    cfg_wdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [bpc_pkg::OUT_BITS-1:0]    m_axis_tdata,
    output logic                            m_axis_tuser
);
    import bpc_pkg::*;

    // configuration
    logic [CFG_BITS-1:0] time_down_reg, time_up_reg, relay_wait_reg, end_offset_reg;
    logic [7:0]          slat_time_reg;

    // latched word
    logic       op_reg;
    logic [7:0] level_reg;

    // blind state
    logic [TIME_BITS-1:0] time_now_reg, run_start_reg, next_event_reg;
    logic [TIME_BITS-1:0] run_start_next, next_event_next;
    motion_t              pending_reg, present_reg, pending_next, present_next;
    logic [POS_BITS-1:0]  target_reg, actual_pos_reg, actual_ang_reg;
    logic [POS_BITS-1:0]  target_next, actual_pos_next, actual_ang_next;
    logic                 moving_down_reg, force_reg, motor_reg, dir_reg;
    logic                 moving_down_next, force_next, motor_next, dir_next;

    // divider
    logic [TIME_BITS-1:0] quo_reg;
    logic [CFG_BITS-1:0]  rem_reg, divisor_reg;
    logic [CNT_BITS-1:0]  div_cnt_reg;
    logic                 div_busy_reg;
    logic [CFG_BITS:0]    rem_shift;
    logic [CFG_BITS-1:0]  divisor_sel;

    // result
    logic                out_valid_reg, out_rep_reg, rep;
    logic [POS_BITS-1:0] out_pos_reg;

    logic [TIME_BITS-1:0] due_diff;
    logic                 run_en;
    logic                 level_plain;
    logic [POS_BITS-1:0]  level_target;
    logic [POS_BITS-1:0]  est_pos, est_ang, dist_move, dist_turn;
    logic [23:0]          move_span;
    logic [14:0]          turn_span;

    function automatic logic [POS_BITS-1:0] sat_down(input logic [POS_BITS-1:0] v,
                                                     input logic [TIME_BITS-1:0] q);
        if (q >= TIME_BITS'(v))
        begin
            return '0;
        end
        return v - q[POS_BITS-1:0];
    endfunction

    function automatic logic [POS_BITS-1:0] sat_up(input logic [POS_BITS-1:0] v,
                                                   input logic [TIME_BITS-1:0] q);
        logic [POS_BITS-1:0] room;
        room = POS_MAX - v;
        if (q >= TIME_BITS'(room))
        begin
            return POS_MAX;
        end
        return v + q[POS_BITS-1:0];
    endfunction

    // ---------------------------------------------------------------- decode
    assign due_diff    = time_now_reg - next_event_reg;
    assign run_en      = force_reg || !due_diff[TIME_BITS-1];
    assign level_plain = (level_reg != LEVEL_TOGGLE) && (level_reg != LEVEL_STOP);
    assign level_target = (level_reg[7:1] > POS_MAX) ? POS_MAX : level_reg[7:1];

    assign stat.need_div = (op_reg == OP_TICK)
        ? (run_en && force_reg && (pending_reg == MS_STOP))
        : (level_plain && ((present_reg == MS_TURN) || (present_reg == MS_MOVE)));
    assign stat.div_last = div_busy_reg && (div_cnt_reg == '0);
    assign stat.out_free = !out_valid_reg || m_axis_tready;

    // a zero per-percent time counts as one
    always_comb
    begin
        if (present_reg == MS_MOVE)
        begin
            divisor_sel = moving_down_reg ? time_down_reg : time_up_reg;
        end
        else
        begin
            divisor_sel = CFG_BITS'(slat_time_reg);
        end
        if (divisor_sel == '0)
        begin
            divisor_sel = CFG_BITS'(1);
        end
    end

    // restoring divide of elapsed run time, one quotient bit a cycle
    assign rem_shift = {rem_reg, quo_reg[TIME_BITS-1]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_busy_reg <= 1'b0;
            div_cnt_reg  <= '0;
        end
        else if (cmd.div_start)
        begin
            div_busy_reg <= 1'b1;
            div_cnt_reg  <= CNT_BITS'(TIME_BITS - 1);
        end
        else if (div_busy_reg)
        begin
            div_cnt_reg <= div_cnt_reg - 1'b1;
            if (div_cnt_reg == '0)
            begin
                div_busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            quo_reg     <= time_now_reg - run_start_reg;
            rem_reg     <= '0;
            divisor_reg <= divisor_sel;
        end
        else if (div_busy_reg)
        begin
            if (rem_shift >= {1'b0, divisor_reg})
            begin
                rem_reg <= CFG_BITS'(rem_shift - {1'b0, divisor_reg});
                quo_reg <= {quo_reg[TIME_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_shift[CFG_BITS-1:0];
                quo_reg <= {quo_reg[TIME_BITS-2:0], 1'b0};
            end
        end
    end

    // estimate from the quotient: position only while moving, else slat angle
    always_comb
    begin
        est_pos = actual_pos_reg;
        est_ang = actual_ang_reg;
        if (present_reg == MS_MOVE)
        begin
            if (moving_down_reg)
            begin
                est_pos = sat_up(actual_pos_reg, quo_reg);
                est_ang = POS_MAX;
            end
            else
            begin
                est_pos = sat_down(actual_pos_reg, quo_reg);
                est_ang = '0;
            end
        end
        else
        begin
            est_ang = moving_down_reg ? sat_up(actual_ang_reg, quo_reg)
                                      : sat_down(actual_ang_reg, quo_reg);
        end
    end

    // travel spans
    always_comb
    begin
        dist_move = '0;
        if (!moving_down_reg && (actual_pos_reg > target_reg))
        begin
            dist_move = actual_pos_reg - target_reg;
        end
        else if (moving_down_reg && (target_reg > actual_pos_reg))
        begin
            dist_move = target_reg - actual_pos_reg;
        end
        move_span = 24'(dist_move) * 24'(moving_down_reg ? time_down_reg : time_up_reg);
        if ((target_reg == '0) || (target_reg == POS_MAX))
        begin
            move_span = move_span + 24'(end_offset_reg);
        end
        dist_turn = moving_down_reg ? (POS_MAX - actual_ang_reg) : actual_ang_reg;
        turn_span = 15'(dist_turn) * 15'(slat_time_reg);
    end

    // ---------------------------------------------------------------- update
    always_comb
    begin
        run_start_next   = run_start_reg;
        next_event_next  = next_event_reg;
        pending_next     = pending_reg;
        present_next     = present_reg;
        target_next      = target_reg;
        actual_pos_next  = actual_pos_reg;
        actual_ang_next  = actual_ang_reg;
        moving_down_next = moving_down_reg;
        force_next       = force_reg;
        motor_next       = motor_reg;
        dir_next         = dir_reg;
        rep              = 1'b0;
        if (op_reg == OP_TICK)
        begin
            if (run_en)
            begin
                case (pending_reg)
                    MS_ROFF:
                    begin
                        dir_next        = 1'b1;
                        present_next    = MS_ROFF;
                        next_event_next = time_now_reg + RELAY_OFF_DELAY;
                    end
                    MS_WAIT:
                    begin
                        moving_down_next = target_reg > actual_pos_reg;
                        dir_next         = target_reg > actual_pos_reg;
                        present_next     = MS_WAIT;
                        pending_next     = MS_TURN;
                        force_next       = 1'b0;
                        next_event_next  = time_now_reg + TIME_BITS'(relay_wait_reg);
                    end
                    MS_MOVE:
                    begin
                        motor_next      = 1'b0;
                        run_start_next  = time_now_reg;
                        present_next    = MS_MOVE;
                        pending_next    = MS_STOP;
                        force_next      = 1'b0;
                        next_event_next = time_now_reg + TIME_BITS'(move_span);
                    end
                    MS_STOP:
                    begin
                        if (force_reg)
                        begin
                            force_next      = 1'b0;
                            actual_pos_next = est_pos;
                            actual_ang_next = est_ang;
                            target_next     = est_pos;
                        end
                        else
                        begin
                            actual_pos_next = target_reg;
                            actual_ang_next = moving_down_reg ? POS_MAX : '0;
                        end
                        motor_next      = 1'b1;
                        present_next    = MS_STOP;
                        pending_next    = MS_ROFF;
                        next_event_next = time_now_reg + TIME_BITS'(relay_wait_reg);
                        rep             = 1'b1;
                    end
                    MS_TURN:
                    begin
                        motor_next      = 1'b0;
                        run_start_next  = time_now_reg;
                        present_next    = MS_TURN;
                        pending_next    = MS_MOVE;
                        next_event_next = time_now_reg + TIME_BITS'(turn_span);
                    end
                    MS_SWDIR:
                    begin
                        motor_next      = 1'b1;
                        present_next    = MS_SWDIR;
                        pending_next    = MS_WAIT;
                        force_next      = 1'b0;
                        next_event_next = time_now_reg + TIME_BITS'(relay_wait_reg);
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
        else if (level_reg == LEVEL_TOGGLE)
        begin
            force_next = 1'b1;
            if (present_reg == MS_TURN)
            begin
                pending_next = MS_STOP;
            end
            if ((present_reg == MS_STOP) || (present_reg == MS_ROFF))
            begin
                target_next  = moving_down_reg ? '0 : POS_MAX;
                pending_next = MS_WAIT;
            end
        end
        else if (level_reg == LEVEL_STOP)
        begin
            pending_next = MS_STOP;
            force_next   = 1'b1;
        end
        else
        begin
            target_next = level_target;
            if ((present_reg == MS_TURN) || (present_reg == MS_MOVE))
            begin
                actual_pos_next = est_pos;
                actual_ang_next = est_ang;
                // new target lies behind the direction of travel
                if ((!moving_down_reg && (level_target > est_pos)) ||
                    (moving_down_reg && (level_target < est_pos)))
                begin
                    pending_next = MS_SWDIR;
                    force_next   = 1'b1;
                end
                else if (present_reg == MS_MOVE)
                begin
                    pending_next = MS_MOVE;
                    force_next   = 1'b1;
                end
            end
            else
            begin
                pending_next = MS_WAIT;
                force_next   = 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------- registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_down_reg   <= RST_TIME_DOWN;
            time_up_reg     <= RST_TIME_UP;
            slat_time_reg   <= RST_SLAT_TIME;
            relay_wait_reg  <= RST_RELAY_WAIT;
            end_offset_reg  <= RST_END_OFFSET;
            time_now_reg    <= '0;
            run_start_reg   <= '0;
            next_event_reg  <= '0;
            pending_reg     <= MS_STOP;
            present_reg     <= MS_STOP;
            target_reg      <= '0;
            actual_pos_reg  <= POS_RESET;
            actual_ang_reg  <= POS_RESET;
            moving_down_reg <= 1'b0;
            force_reg       <= 1'b0;
            motor_reg       <= 1'b1;
            dir_reg         <= 1'b1;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_TIME_DOWN:  time_down_reg  <= cfg_wdata;
                    REG_TIME_UP:    time_up_reg    <= cfg_wdata;
                    REG_SLAT_TIME:  slat_time_reg  <= cfg_wdata[7:0];
                    REG_RELAY_WAIT: relay_wait_reg <= cfg_wdata;
                    REG_END_OFFSET: end_offset_reg <= cfg_wdata;
                    default:
                    begin
                    end
                endcase
            end
            if (cmd.load_item && (in_op == OP_TICK))
            begin
                time_now_reg <= time_now_reg + 1'b1;
            end
            if (cmd.apply)
            begin
                run_start_reg   <= run_start_next;
                next_event_reg  <= next_event_next;
                pending_reg     <= pending_next;
                present_reg     <= present_next;
                target_reg      <= target_next;
                actual_pos_reg  <= actual_pos_next;
                actual_ang_reg  <= actual_ang_next;
                moving_down_reg <= moving_down_next;
                force_reg       <= force_next;
                motor_reg       <= motor_next;
                dir_reg         <= dir_next;
                out_valid_reg   <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            op_reg    <= in_op;
            level_reg <= in_level;
        end
        if (cmd.apply)
        begin
            out_rep_reg <= rep;
            out_pos_reg <= rep ? actual_pos_next : '0;
        end
    end

    // pins, target and state change only on an update, which waits for a free slot
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_rep_reg;
    assign m_axis_tdata  = {5'd0, present_reg, target_reg, out_pos_reg, dir_reg, motor_reg};

endmodule

>>> tb/blind_position_controller_tb.sv
// Self-checking testbench of the blind position controller: opening table, then random phases.
`timescale 1ns / 1ps

module blind_position_controller_tb;

    import bpc_pkg::*;

    typedef struct packed {
        logic                motor_pin;
        logic                dir_pin;
        logic                reported;
        logic [POS_BITS-1:0] report_pos;
        logic [POS_BITS-1:0] target_pos;
        motion_t             state;
    } relay_word_t;

    typedef struct packed {
        logic        op;
        logic [7:0]  level;
        logic        typed;
        relay_word_t want;
    } opening_row_t;

    localparam int OPENING_ROWS = 25;
    localparam int PHASES       = 6;

    // rows with typed=1 carry their result; the rest go through the predictor
    localparam opening_row_t OPENING_WORDS [OPENING_ROWS] = '{
        '{OP_TICK,  8'd0,   1'b1, '{1'b1, 1'b1, 1'b1, 7'd0, 7'd0,   MS_STOP}},
        '{OP_LEVEL, 8'd255, 1'b1, '{1'b1, 1'b1, 1'b0, 7'd0, 7'd100, MS_STOP}},
        '{OP_TICK,  8'd0,   1'b0, '0},
        '{OP_LEVEL, 8'd255, 1'b0, '0},
        '{OP_TICK,  8'd255, 1'b0, '0},
        '{OP_TICK,  8'd0,   1'b0, '0},
        '{OP_LEVEL, 8'd160, 1'b0, '0},
        '{OP_TICK,  8'd0,   1'b0, '0},
        '{OP_LEVEL, 8'd201, 1'b0, '0},
        '{OP_TICK,  8'd0,   1'b1, '{1'b1, 1'b1, 1'b1, 7'd0, 7'd0,   MS_STOP}},
        '{OP_LEVEL, 8'd255, 1'b0, '0},
        '{OP_TICK,  8'd0,   1'b0, '0},
        '{OP_LEVEL, 8'd255, 1'b0, '0},
        '{OP_TICK,  8'd0,   1'b0, '0},
        '{OP_TICK,  8'd0,   1'b0, '0},
        '{OP_LEVEL, 8'd254, 1'b0, '0},
        '{OP_TICK,  8'd0,   1'b0, '0},
        '{OP_TICK,  8'd0,   1'b0, '0},
        '{OP_LEVEL, 8'd255, 1'b0, '0},
        '{OP_TICK,  8'd0,   1'b0, '0},
        '{OP_LEVEL, 8'd2,   1'b0, '0},
        '{OP_LEVEL, 8'd203, 1'b0, '0},
        '{OP_LEVEL, 8'd201, 1'b0, '0},
        '{OP_TICK,  8'd0,   1'b0, '0},
        '{OP_LEVEL, 8'd255, 1'b0, '0}
    };

    // per phase: time down, time up, slat time, relay wait, end offset
    localparam logic [CFG_BITS-1:0] PHASE_REGS [PHASES][5] = '{
        '{16'd2,     16'd3,     16'd1,      16'd2,     16'd3},
        '{16'd65535, 16'd1,     16'd255,    16'd0,     16'd65535},
        '{16'd1,     16'd65535, 16'd1,      16'd0,     16'd0},
        '{16'd0,     16'd0,     16'h0301,   16'd1,     16'd0},
        '{16'd1,     16'd1,     16'd2,      16'd65535, 16'd1},
        '{16'd100,   16'd100,   16'd10,     16'd200,   16'd1000}
    };
    localparam int PHASE_WORDS [PHASES] = '{150, 60, 60, 80, 40, 60};

    logic                clk;
    logic                rst_n         = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [IN_BITS-1:0]  s_axis_tdata  = '0;
    logic                s_axis_tuser  = 1'b0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [OUT_BITS-1:0] m_axis_tdata;
    logic                m_axis_tuser;
    logic                cfg_we        = 1'b0;
    logic [IDX_BITS-1:0] cfg_index     = '0;
    logic [CFG_BITS-1:0] cfg_wdata     = '0;

    blind_position_controller u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    // blind state as the testbench tracks it
    logic [TIME_BITS-1:0] ms_now     = '0;
    logic [TIME_BITS-1:0] run_t0     = '0;
    logic [TIME_BITS-1:0] due_at     = '0;
    motion_t              queued     = MS_STOP;
    motion_t              mode       = MS_STOP;
    logic [POS_BITS-1:0]  goal       = 7'd0;
    logic [POS_BITS-1:0]  pos        = POS_RESET;
    logic [POS_BITS-1:0]  tilt       = POS_RESET;
    logic                 going_down = 1'b0;
    logic                 forced     = 1'b0;
    logic                 motor_q    = 1'b1;
    logic                 dir_q      = 1'b1;

    logic [CFG_BITS-1:0]  ms_down    = RST_TIME_DOWN;
    logic [CFG_BITS-1:0]  ms_up      = RST_TIME_UP;
    logic [7:0]           ms_slat    = RST_SLAT_TIME;
    logic [CFG_BITS-1:0]  relay_gap  = RST_RELAY_WAIT;
    logic [CFG_BITS-1:0]  end_extra  = RST_END_OFFSET;

    relay_word_t awaited_words [$];
    relay_word_t seen_word;
    relay_word_t head_word;
    int          mismatches = 0;
    int          words_seen = 0;
    int          tx_calm    = 0;

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial begin
        #2_000_000;
        $display("blind_position_controller_tb failed");
        $finish;
    end

    // ---------------------------------------------------------------- predictor

    function automatic logic [TIME_BITS-1:0] per_pct(logic [TIME_BITS-1:0] v);
        return (v == '0) ? 32'd1 : v;
    endfunction

    function automatic logic [POS_BITS-1:0] sat_fall(logic [POS_BITS-1:0] v,
                                                     logic [TIME_BITS-1:0] q);
        return (q >= {25'd0, v}) ? 7'd0 : v - q[POS_BITS-1:0];
    endfunction

    function automatic logic [POS_BITS-1:0] sat_rise(logic [POS_BITS-1:0] v,
                                                     logic [TIME_BITS-1:0] q);
        return (q >= {25'd0, POS_MAX - v}) ? POS_MAX : v + q[POS_BITS-1:0];
    endfunction

    function automatic logic [TIME_BITS-1:0] after_ms(logic [TIME_BITS-1:0] d);
        return ms_now + d;
    endfunction

    // run time since the last start, turned into position or slat travel
    function automatic void update_estimate();
        logic [TIME_BITS-1:0] run_ms;
        logic [TIME_BITS-1:0] q;
        run_ms = ms_now - run_t0;
        if (mode == MS_MOVE) begin
            if (!going_down) begin
                pos  = sat_fall(pos, run_ms / per_pct({16'd0, ms_up}));
                tilt = 7'd0;
            end else begin
                pos  = sat_rise(pos, run_ms / per_pct({16'd0, ms_down}));
                tilt = POS_MAX;
            end
        end else begin
            q    = run_ms / per_pct({24'd0, ms_slat});
            tilt = going_down ? sat_rise(tilt, q) : sat_fall(tilt, q);
        end
    endfunction

    // returns 1 when the tick entered stop
    function automatic logic tick_machine();
        logic [TIME_BITS-1:0] lag;
        logic [TIME_BITS-1:0] span;
        lag = ms_now - due_at;
        if (!forced && lag[TIME_BITS-1])
            return 1'b0;
        case (queued)
            MS_ROFF: begin
                dir_q  = 1'b1;
                mode   = MS_ROFF;
                due_at = after_ms(RELAY_OFF_DELAY);
            end
            MS_WAIT: begin
                going_down = goal > pos;
                dir_q      = going_down;
                mode       = MS_WAIT;
                queued     = MS_TURN;
                forced     = 1'b0;
                due_at     = after_ms({16'd0, relay_gap});
            end
            MS_MOVE: begin
                motor_q = 1'b0;
                run_t0  = ms_now;
                mode    = MS_MOVE;
                queued  = MS_STOP;
                span    = '0;
                if (!going_down && pos > goal)
                    span = 32'(pos - goal) * {16'd0, ms_up};
                else if (going_down && goal > pos)
                    span = 32'(goal - pos) * {16'd0, ms_down};
                if (goal == 7'd0 || goal == POS_MAX)
                    span = span + {16'd0, end_extra};
                due_at = after_ms(span);
                forced = 1'b0;
            end
            MS_STOP: begin
                if (forced) begin
                    forced = 1'b0;
                    update_estimate();
                    goal = pos;
                end else begin
                    pos  = goal;
                    tilt = going_down ? POS_MAX : 7'd0;
                end
                motor_q = 1'b1;
                mode    = MS_STOP;
                queued  = MS_ROFF;
                due_at  = after_ms({16'd0, relay_gap});
                return 1'b1;
            end
            MS_TURN: begin
                motor_q = 1'b0;
                run_t0  = ms_now;
                mode    = MS_TURN;
                queued  = MS_MOVE;
                span    = going_down ? 32'(POS_MAX - tilt) : 32'(tilt);
                due_at  = after_ms(span * {24'd0, ms_slat});
            end
            MS_SWDIR: begin
                motor_q = 1'b1;
                mode    = MS_SWDIR;
                queued  = MS_WAIT;
                forced  = 1'b0;
                due_at  = after_ms({16'd0, relay_gap});
            end
            default: ;
        endcase
        return 1'b0;
    endfunction

    function automatic void take_level(logic [7:0] lv);
        if (lv == LEVEL_TOGGLE) begin
            if (mode == MS_TURN)
                queued = MS_STOP;
            forced = 1'b1;
            if (mode == MS_STOP || mode == MS_ROFF) begin
                goal   = going_down ? 7'd0 : POS_MAX;
                queued = MS_WAIT;
            end
        end else if (lv == LEVEL_STOP) begin
            queued = MS_STOP;
            forced = 1'b1;
        end else begin
            goal = (lv[7:1] > POS_MAX) ? POS_MAX : lv[7:1];
            if (mode == MS_TURN || mode == MS_MOVE) begin
                update_estimate();
                if ((!going_down && goal > pos) || (going_down && goal < pos)) begin
                    queued = MS_SWDIR;
                    forced = 1'b1;
                end else if (mode == MS_MOVE) begin
                    queued = MS_MOVE;
                    forced = 1'b1;
                end
            end else begin
                queued = MS_WAIT;
                forced = 1'b1;
            end
        end
    endfunction

    function automatic relay_word_t advance_blind(logic op, logic [7:0] lv);
        relay_word_t r;
        logic        rep;
        rep = 1'b0;
        if (op == OP_TICK) begin
            ms_now = ms_now + 1;
            rep    = tick_machine();
        end else begin
            take_level(lv);
        end
        r.motor_pin  = motor_q;
        r.dir_pin    = dir_q;
        r.reported   = rep;
        r.report_pos = rep ? pos : 7'd0;
        r.target_pos = goal;
        r.state      = mode;
        return r;
    endfunction

    // ---------------------------------------------------------------- stimulus

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] pick_level();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30)
            return LEVEL_TOGGLE;
        else if (r < 42)
            return LEVEL_STOP;
        else if (r < 52)
            return 8'($urandom_range(202, 254));
        else if (r < 62)
            return 8'($urandom_range(0, 255));
        return 8'($urandom_range(0, 200));
    endfunction

    task automatic send_word(input logic op, input logic [7:0] lv,
                             input logic typed, input relay_word_t want);
        int          gap;
        relay_word_t next;
        gap = 0;
        if (tx_calm > 0)
            tx_calm = tx_calm - 1;
        else if ($urandom_range(0, 30) == 0)
            tx_calm = $urandom_range(20, 60);
        else if ($urandom_range(0, 2) == 0)
            gap = idle_len();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= lv;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        next = advance_blind(op, lv);
        awaited_words.push_back(typed ? want : next);
    endtask

    // let every result out, then allow for the divider before touching registers
    task automatic drain_words();
        s_axis_tvalid <= 1'b0;
        while (awaited_words.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic load_phase(input int p);
        logic [IDX_BITS-1:0] idx;
        logic [CFG_BITS-1:0] val;
        for (int r = 0; r < 5; r++) begin
            idx = IDX_BITS'(r);
            val = PHASE_REGS[p][r];
            cfg_we    <= 1'b1;
            cfg_index <= idx;
            cfg_wdata <= val;
            @(posedge clk);
            case (idx)
                REG_TIME_DOWN:  ms_down   = val;
                REG_TIME_UP:    ms_up     = val;
                REG_SLAT_TIME:  ms_slat   = val[7:0];
                REG_RELAY_WAIT: relay_gap = val;
                REG_END_OFFSET: end_extra = val;
                default: ;
            endcase
        end
        cfg_we <= 1'b0;
    endtask

    initial begin : stimulus
        logic op;
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < OPENING_ROWS; i++)
            send_word(OPENING_WORDS[i].op, OPENING_WORDS[i].level,
                      OPENING_WORDS[i].typed, OPENING_WORDS[i].want);
        drain_words();

        for (int p = 0; p < PHASES; p++) begin
            load_phase(p);
            for (int n = 0; n < PHASE_WORDS[p]; n++) begin
                // level field rides along on ticks too, where it is ignored
                op = ($urandom_range(0, 99) < 82) ? OP_TICK : OP_LEVEL;
                send_word(op, (op == OP_TICK) ? 8'($urandom_range(0, 255)) : pick_level(),
                          1'b0, '0);
            end
            drain_words();
        end

        if (mismatches == 0)
            $display("blind_position_controller_tb passed");
        else
            $display("blind_position_controller_tb failed");
        $finish;
    end

    // ---------------------------------------------------------------- checking

    initial begin : result_ready
        int hold;
        int calm;
        hold = 0;
        calm = 0;
        forever begin
            @(posedge clk);
            if (hold > 0) begin
                hold = hold - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                if (calm > 0)
                    calm = calm - 1;
                else if ($urandom_range(0, 40) == 0)
                    calm = $urandom_range(20, 80);
                else if ($urandom_range(0, 3) == 0)
                    hold = idle_len();
            end
        end
    end

    task automatic flag_mismatch(input string what, input int got, input int want);
        mismatches = mismatches + 1;
        $display("%0t word %0d: %s is %0d, should be %0d",
                 $time, words_seen, what, got, want);
    endtask

    always @(posedge clk) begin
        if (rst_n && m_axis_tvalid && m_axis_tready) begin
            seen_word.motor_pin  = m_axis_tdata[0];
            seen_word.dir_pin    = m_axis_tdata[1];
            seen_word.report_pos = m_axis_tdata[8:2];
            seen_word.target_pos = m_axis_tdata[15:9];
            seen_word.state      = motion_t'(m_axis_tdata[18:16]);
            seen_word.reported   = m_axis_tuser;
            if (awaited_words.size() == 0) begin
                flag_mismatch("word with nothing awaited", 1, 0);
            end else begin
                head_word = awaited_words.pop_front();
                if (seen_word.motor_pin !== head_word.motor_pin)
                    flag_mismatch("motor_relay_pin", int'(seen_word.motor_pin),
                                  int'(head_word.motor_pin));
                if (seen_word.dir_pin !== head_word.dir_pin)
                    flag_mismatch("direction_relay_pin", int'(seen_word.dir_pin),
                                  int'(head_word.dir_pin));
                if (seen_word.reported !== head_word.reported)
                    flag_mismatch("report_valid", int'(seen_word.reported),
                                  int'(head_word.reported));
                if (seen_word.report_pos !== head_word.report_pos)
                    flag_mismatch("report_position", int'(seen_word.report_pos),
                                  int'(head_word.report_pos));
                if (seen_word.target_pos !== head_word.target_pos)
                    flag_mismatch("requested_position", int'(seen_word.target_pos),
                                  int'(head_word.target_pos));
                if (seen_word.state !== head_word.state)
                    flag_mismatch("motion_state", int'(seen_word.state),
                                  int'(head_word.state));
                if (m_axis_tdata[OUT_BITS-1:19] !== '0)
                    flag_mismatch("padding bits", int'(m_axis_tdata[OUT_BITS-1:19]), 0);
            end
            words_seen = words_seen + 1;
        end
    end

endmodule
